>>> rtl/slmc_pkg.sv
// Package for the street lamp mode controller: word types, codes and constants.
// No dependencies; every other file imports it.
package slmc_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_LIGHT  = 2'd2,
    OP_SECOND = 2'd3
  } op_t;

  // Command awaiting its payload
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_TIME  = 3'd1,
    CMD_LIGHT = 3'd2,
    CMD_ALIVE = 3'd3,
    CMD_CLOCK = 3'd4,
    CMD_MODE  = 3'd5
  } cmd_t;

  // What a run of results carries
  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_REPLY = 2'd1,
    RUN_LOAD  = 2'd2,
    RUN_PARAM = 2'd3
  } run_kind_t;

  localparam logic [7:0] MODE_TIME   = 8'd0;
  localparam logic [7:0] MODE_DARK   = 8'd1;
  localparam logic [7:0] MODE_MOTION = 8'd2;
  localparam logic [7:0] MODE_ON     = 8'd3;
  localparam logic [7:0] MODE_OFF    = 8'd4;

  localparam logic [7:0] CHR_ACK   = 8'h41; // 'A'
  localparam logic [7:0] CHR_ERR   = 8'h45; // 'E'
  localparam logic [7:0] CHR_TIME  = 8'h74; // 't'
  localparam logic [7:0] CHR_LIGHT = 8'h6C; // 'l'
  localparam logic [7:0] CHR_ALIVE = 8'h61; // 'a'
  localparam logic [7:0] CHR_CLOCK = 8'h67; // 'g'
  localparam logic [7:0] CHR_MODE  = 8'h6D; // 'm'
  localparam logic [7:0] CHR_PARAM = 8'h70; // 'p'

  localparam int unsigned PAYLOAD_MAX = 7;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_MAX);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_MAX - 1);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic       motion_level;
    logic [7:0] light_sample;
  } in_word_t;

  typedef struct packed {
    logic        lamp_on;
    logic [2:0]  active_mode;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic        clock_load;
    logic [7:0]  load_second;
    logic [7:0]  load_minute;
    logic [7:0]  load_hour;
    logic [7:0]  load_day;
    logic [7:0]  load_month;
    logic [15:0] load_year;
  } out_word_t;

  // One accepted input word condensed into the results it causes
  typedef struct packed {
    logic                           lamp;
    logic [2:0]                     mode;
    run_kind_t                      kind;
    logic [PAYLOAD_MAX-1:0][7:0]    bytes;
  } run_t;

endpackage

>>> rtl/street_lamp_mode_controller_unit.sv
// Top level of the street lamp mode controller.
// Depends on slmc_pkg, slmc_ctrl and slmc_emit.
//
// Usage notes:
//  - in_valid/in_stall/in_word carry one event word: a command byte, a control
//    tick with hour, minute and motion, a light sample, or a one-second tick.
//  - out_valid/out_stall/out_word carry result words. Every event gives one
//    word; a 'p' command gives seven, the parameter bytes in order. The last
//    word of each event has last_of_run set.
//  - All settings and lamp state are updated in the cycle an event is taken;
//    with no run ahead of it, its first result word shows on the following cycle.
//  - One event per cycle is taken while in_stall is low. Results queue in a
//    two-entry run buffer, so the input keeps flowing while a result waits;
//    in_stall rises only when both entries are held or in reset; full is registered.
//  - A 'p' run is stepped out one word at a time by the word sequencer; events
//    behind it wait in the buffer.
//  - Reset (rst_n low, synchronous) restores the default slot 17:00 to 05:00,
//    mode off, lamp off, hold time 15 s, and empties the buffer. in_stall is
//    held high during reset.
//  - While out_stall is high the presented word holds still.
module street_lamp_mode_controller_unit import slmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic in_fire;
  logic full;
  run_t run;

  assign in_stall = full || !rst_n;
  assign in_fire  = in_valid && !in_stall;

  // settings, mode handling and timers
  slmc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_word (in_word),
    .run     (run)
  );

  // run buffer and word sequencer
  slmc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .run       (run),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTH
  // an accepted event always has a word ready on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("no result after an accepted event");

  // a run that is not finished keeps presenting words
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last_of_run |=> out_valid)
    else $error("run broken off before its last word");

  // a clock load rides only on the closing acknowledge
  a_load_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.clock_load |->
      out_word.tx_valid && out_word.tx_byte == CHR_ACK && out_word.last_of_run)
    else $error("clock load outside acknowledge");

  // no reply byte means a zero byte field
  a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.tx_valid |-> out_word.tx_byte == 8'd0)
    else $error("reply byte set without tx_valid");
`endif

endmodule

>>> rtl/slmc_ctrl.sv
// Control state of the lamp controller: command parser, settings, mode logic, timers.
// Depends on slmc_pkg; produces one run_t per accepted input word.
module slmc_ctrl import slmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_word_t in_word,
  output run_t     run
);

  // floor(x*100/163) == (x*40207) >> 16 for every 8-bit x
  localparam logic [15:0] LIGHT_RECIP = 16'd40207;
  localparam int unsigned LIGHT_SHIFT = 16;
  localparam logic [13:0] MIN_PER_HOUR = 14'd60;
  localparam logic [7:0]  HOLD_MARGIN = 8'd3;

  logic [7:0] mode_now_r, mode_now_nxt, mode_before_r, mode_before_nxt;
  logic [7:0] ssh_r, ssh_nxt, ssm_r, ssm_nxt, seh_r, seh_nxt, sem_r, sem_nxt;
  logic [7:0] dark_r, dark_nxt, hold_r, hold_nxt, light_r, light_nxt;
  logic       armed_r, armed_nxt, motion_r, motion_nxt;
  logic       running_r, running_nxt, lamp_r, lamp_nxt;
  logic [7:0] hcount_r, hcount_nxt;
  cmd_t       pend_r, pend_nxt;
  logic [IDX_W-1:0] pcount_r, pcount_nxt;
  logic [PAYLOAD_MAX-1:0][7:0] store_r;
  logic [PAYLOAD_MAX-1:0][7:0] store_view;
  logic       store_we;

  logic [2:0]  need;
  logic [IDX_W-1:0] pcount_inc;
  logic        slot;
  logic [23:0] light_prod;
  logic [7:0]  delay, hcount_inc;

  function automatic logic [2:0] payload_len(cmd_t c);
    case (c)
      CMD_TIME:  payload_len = 3'd4;
      CMD_LIGHT: payload_len = 3'd1;
      CMD_ALIVE: payload_len = 3'd1;
      CMD_CLOCK: payload_len = 3'd7;
      CMD_MODE:  payload_len = 3'd1;
      default:   payload_len = 3'd0;
    endcase
  endfunction

  // Start and end are open; start after end means the slot wraps past midnight
  function automatic logic slot_hit(logic [4:0] h, logic [5:0] m, logic [7:0] sh,
                                    logic [7:0] sm, logic [7:0] eh, logic [7:0] em);
    logic [13:0] t, s, e;
    t = 14'(h) * MIN_PER_HOUR + 14'(m);
    s = 14'(sh) * MIN_PER_HOUR + 14'(sm);
    e = 14'(eh) * MIN_PER_HOUR + 14'(em);
    slot_hit = (s < e) ? (t > s && t < e) : (t > s || t < e);
  endfunction

  always_comb begin
    for (int i = 0; i < PAYLOAD_MAX; i++) begin
      store_view[i] = (pcount_r == IDX_W'(i)) ? in_word.rx_byte : store_r[i];
    end
  end

  assign need       = payload_len(pend_r);
  assign pcount_inc = pcount_r + IDX_W'(1);
  assign slot       = slot_hit(in_word.now_hour, in_word.now_minute,
                               ssh_r, ssm_r, seh_r, sem_r);
  assign light_prod = 24'(in_word.light_sample) * 24'(LIGHT_RECIP);
  assign delay      = (hold_r > HOLD_MARGIN) ? hold_r - HOLD_MARGIN : 8'd1;
  assign hcount_inc = hcount_r + 8'd1;

  always_comb begin
    mode_now_nxt    = mode_now_r;
    mode_before_nxt = mode_before_r;
    ssh_nxt = ssh_r;
    ssm_nxt = ssm_r;
    seh_nxt = seh_r;
    sem_nxt = sem_r;
    dark_nxt    = dark_r;
    hold_nxt    = hold_r;
    light_nxt   = light_r;
    armed_nxt   = armed_r;
    motion_nxt  = motion_r;
    running_nxt = running_r;
    lamp_nxt    = lamp_r;
    hcount_nxt  = hcount_r;
    pend_nxt    = pend_r;
    pcount_nxt  = pcount_r;
    store_we    = 1'b0;
    run.kind    = RUN_NONE;
    run.bytes   = '0;

    if (in_fire) begin
      case (op_t'(in_word.operation))
        OP_BYTE: begin
          if (pend_r == CMD_NONE) begin
            pcount_nxt = '0;
            case (in_word.rx_byte)
              CHR_TIME:  pend_nxt = CMD_TIME;
              CHR_LIGHT: pend_nxt = CMD_LIGHT;
              CHR_ALIVE: pend_nxt = CMD_ALIVE;
              CHR_CLOCK: pend_nxt = CMD_CLOCK;
              CHR_MODE:  pend_nxt = CMD_MODE;
              CHR_PARAM: begin
                pcount_nxt = pcount_r;
                run.kind   = RUN_PARAM;
                run.bytes  = {hold_r, dark_r, sem_r, seh_r, ssm_r, ssh_r, mode_now_r};
              end
              default: begin
                pcount_nxt   = pcount_r;
                run.kind     = RUN_REPLY;
                run.bytes[0] = CHR_ERR;
              end
            endcase
          end else begin
            store_we = 1'b1;
            if (need == 3'd0) begin
              pend_nxt   = CMD_NONE;
              pcount_nxt = '0;
            end else if (3'(pcount_inc) < need) begin
              pcount_nxt = pcount_inc;
            end else begin
              pend_nxt     = CMD_NONE;
              pcount_nxt   = '0;
              run.kind     = RUN_REPLY;
              run.bytes[0] = CHR_ACK;
              case (pend_r)
                CMD_TIME: begin
                  ssh_nxt = store_view[0];
                  ssm_nxt = store_view[1];
                  seh_nxt = store_view[2];
                  sem_nxt = store_view[3];
                end
                CMD_LIGHT: dark_nxt = store_view[0];
                CMD_ALIVE: hold_nxt = store_view[0];
                CMD_CLOCK: begin
                  run.kind  = RUN_LOAD;
                  run.bytes = store_view;
                end
                CMD_MODE: begin
                  mode_before_nxt = mode_now_r;
                  mode_now_nxt    = store_view[0];
                end
                default: ;
              endcase
            end
          end
        end
        OP_TICK: begin
          // a mode change first forces the lamp in modes on and off and disarms the light check
          if (mode_before_r != mode_now_r) begin
            if (mode_now_r == MODE_ON) begin
              lamp_nxt = 1'b1;
            end else if (mode_now_r == MODE_OFF) begin
              lamp_nxt = 1'b0;
            end
            armed_nxt       = 1'b0;
            mode_before_nxt = mode_now_r;
          end
          case (mode_now_r)
            MODE_TIME: lamp_nxt = slot;
            MODE_DARK: begin
              if (!armed_nxt) begin
                armed_nxt = 1'b1;
              end else begin
                lamp_nxt = slot && (light_r < dark_r);
              end
            end
            MODE_MOTION: begin
              if (!motion_r && in_word.motion_level) begin
                lamp_nxt    = 1'b1;
                running_nxt = 1'b0;
              end else if (motion_r && !in_word.motion_level) begin
                running_nxt = 1'b1;
                hcount_nxt  = '0;
              end
              motion_nxt = in_word.motion_level;
            end
            default: ;
          endcase
        end
        OP_LIGHT: light_nxt = light_prod[LIGHT_SHIFT +: 8];
        OP_SECOND: begin
          if (running_r) begin
            hcount_nxt = hcount_inc;
            if (hcount_inc >= delay) begin
              running_nxt = 1'b0;
              lamp_nxt    = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end

    run.lamp = lamp_nxt;
    run.mode = mode_now_nxt[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_now_r    <= MODE_OFF;
      mode_before_r <= MODE_OFF;
      ssh_r     <= 8'd17;
      ssm_r     <= 8'd0;
      seh_r     <= 8'd5;
      sem_r     <= 8'd0;
      dark_r    <= 8'd0;
      hold_r    <= 8'd15;
      light_r   <= 8'd0;
      armed_r   <= 1'b0;
      motion_r  <= 1'b0;
      running_r <= 1'b0;
      lamp_r    <= 1'b0;
      hcount_r  <= 8'd0;
      pend_r    <= CMD_NONE;
      pcount_r  <= '0;
    end else begin
      mode_now_r    <= mode_now_nxt;
      mode_before_r <= mode_before_nxt;
      ssh_r     <= ssh_nxt;
      ssm_r     <= ssm_nxt;
      seh_r     <= seh_nxt;
      sem_r     <= sem_nxt;
      dark_r    <= dark_nxt;
      hold_r    <= hold_nxt;
      light_r   <= light_nxt;
      armed_r   <= armed_nxt;
      motion_r  <= motion_nxt;
      running_r <= running_nxt;
      lamp_r    <= lamp_nxt;
      hcount_r  <= hcount_nxt;
      pend_r    <= pend_nxt;
      pcount_r  <= pcount_nxt;
    end
  end

  // payload bytes: no reset, only read once written
  always_ff @(posedge clk) begin
    if (store_we && pcount_r != IDX_LAST + IDX_W'(1)) begin
      store_r <= store_view;
    end
  end

endmodule

>>> rtl/slmc_emit.sv
// Result side: two-entry queue of runs and the sequencer that turns a run into words.
// Depends on slmc_pkg.
module slmc_emit import slmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  run_t      run,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  run_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  run_t       head;
  logic       last, out_fire, pop;

  assign head      = q_r[rd_ptr_r];
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign last      = (head.kind != RUN_PARAM) || (idx_r == IDX_LAST);
  assign out_fire  = out_valid && !out_stall;
  assign pop       = out_fire && last;

  always_comb begin
    out_word             = '0;
    out_word.lamp_on     = head.lamp;
    out_word.active_mode = head.mode;
    out_word.last_of_run = last;
    case (head.kind)
      RUN_NONE: ;
      RUN_REPLY: begin
        out_word.tx_valid = 1'b1;
        out_word.tx_byte  = head.bytes[0];
      end
      RUN_LOAD: begin
        out_word.tx_valid    = 1'b1;
        out_word.tx_byte     = CHR_ACK;
        out_word.clock_load  = 1'b1;
        out_word.load_second = head.bytes[0];
        out_word.load_minute = head.bytes[1];
        out_word.load_hour   = head.bytes[2];
        out_word.load_day    = head.bytes[3];
        out_word.load_month  = head.bytes[4];
        out_word.load_year   = {head.bytes[5], head.bytes[6]};
      end
      RUN_PARAM: begin
        out_word.tx_valid = 1'b1;
        out_word.tx_byte  = head.bytes[idx_r];
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (out_fire) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= run;
    end
  end

endmodule
